@@ rtl/bpq_pkg.sv @@
package bpq_pkg;

  // Queue capacity and derived widths
  localparam int DEPTH    = 16;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int VALUE_W  = 32;
  localparam int PRI_W    = 8;
  localparam int ENTRY_W  = VALUE_W + PRI_W;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Input opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Register index (paddr[2])
  localparam logic REG_MIN_PRIORITY = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  // Result word from the sequencer
  typedef struct packed {
    logic                     valid;
    logic signed [VALUE_W-1:0] value;
    logic [PRI_W-1:0]         priority_v;
    status_t                  status;
    logic [FILL_W-1:0]        fill_count;
  } result_t;

endpackage

@@ rtl/bpq_ram.sv @@
module bpq_ram #(
  parameter int DATA_W = 40,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bpq_regs.sv @@
module bpq_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpq_pkg::APB_AW-1:0]  paddr,
  input  logic [bpq_pkg::APB_DW-1:0]  pwdata,
  output logic [bpq_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [bpq_pkg::PRI_W-1:0]   min_priority
);
  import bpq_pkg::*;

  logic [PRI_W-1:0] min_pri_r;
  logic [PRI_W-1:0] min_pri_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Decode the write; other addresses are ignored
  always_comb begin
    min_pri_nxt = min_pri_r;
    if (wr_en && (paddr[2] == REG_MIN_PRIORITY)) begin
      min_pri_nxt = pwdata[PRI_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pri_r <= '0;
    end else begin
      min_pri_r <= min_pri_nxt;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIN_PRIORITY) begin
      prdata = APB_DW'(min_pri_r);
    end
  end

  assign min_priority = min_pri_r;

endmodule

@@ rtl/bpq_seq.sv @@
module bpq_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               opcode,
  input  logic signed [bpq_pkg::VALUE_W-1:0] value,
  input  logic [bpq_pkg::PRI_W-1:0]          priority_in,
  input  logic [bpq_pkg::PRI_W-1:0]          min_priority,
  output logic                               busy,
  output bpq_pkg::result_t                   result,
  // Entry memory
  output logic                               mem_we,
  output logic [bpq_pkg::ADDR_W-1:0]         mem_waddr,
  output logic [bpq_pkg::ENTRY_W-1:0]        mem_wdata,
  output logic [bpq_pkg::ADDR_W-1:0]         mem_raddr,
  input  logic [bpq_pkg::ENTRY_W-1:0]        mem_rdata
);
  import bpq_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic                found_r, found_nxt;
  logic [ADDR_W-1:0]   best_idx_r, best_idx_nxt;
  logic [PRI_W-1:0]    best_pri_r, best_pri_nxt;
  logic [VALUE_W-1:0]  best_val_r, best_val_nxt;
  result_t             res_r, res_nxt;

  logic                accept;
  logic [PRI_W-1:0]    rd_pri;
  logic [VALUE_W-1:0]  rd_val;
  logic                take;
  logic                last;
  logic [CNT_W-1:0]    count_m1;
  logic [CNT_W-1:0]    next_slot;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign rd_pri   = mem_rdata[PRI_W-1:0];
  assign rd_val   = mem_rdata[ENTRY_W-1:PRI_W];
  assign count_m1 = count_r - CNT_W'(1);
  assign last     = (CNT_W'(idx_r) == count_m1);
  assign take     = (rd_pri >= min_priority) && (!found_r || (rd_pri > best_pri_r));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_pri_nxt = best_pri_r;
    best_val_nxt = best_val_r;
    res_nxt      = res_r;
    res_nxt.valid = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = count_r[ADDR_W-1:0];
    mem_wdata    = {value, priority_in};
    mem_raddr    = '0;
    next_slot    = '0;

    case (state_r)
      // Take a word: pushes and pops on an empty queue finish here, other pops start the scan at slot 0
      S_IDLE: begin
        if (accept) begin
          res_nxt.valid      = 1'b1;
          res_nxt.value      = '0;
          res_nxt.priority_v = '0;
          res_nxt.fill_count = FILL_W'(count_r);
          if (opcode == OP_PUSH) begin
            if (count_r == CNT_W'(DEPTH)) begin
              res_nxt.status = ST_FULL;
            end else begin
              mem_we             = 1'b1;
              count_nxt          = count_r + CNT_W'(1);
              res_nxt.status     = ST_PUSHED;
              res_nxt.fill_count = FILL_W'(count_r + CNT_W'(1));
            end
          end else if (count_r == '0) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            res_nxt.valid = 1'b0;
            mem_raddr     = '0;
            idx_nxt       = '0;
            found_nxt     = 1'b0;
            state_nxt     = S_SCAN;
          end
        end
      end

      // Compare one stored entry per cycle against the best so far
      S_SCAN: begin
        if (take) begin
          found_nxt    = 1'b1;
          best_idx_nxt = idx_r;
          best_pri_nxt = rd_pri;
          best_val_nxt = rd_val;
        end
        if (!last) begin
          idx_nxt   = idx_r + ADDR_W'(1);
          mem_raddr = idx_r + ADDR_W'(1);
        end else begin
          res_nxt.valid      = 1'b1;
          res_nxt.fill_count = FILL_W'(count_r);
          res_nxt.value      = '0;
          res_nxt.priority_v = '0;
          res_nxt.status     = ST_EMPTY;
          state_nxt          = S_IDLE;
          if (found_nxt) begin
            res_nxt.value      = best_val_nxt;
            res_nxt.priority_v = best_pri_nxt;
            res_nxt.status     = ST_POPPED;
            res_nxt.fill_count = FILL_W'(count_m1);
            next_slot          = CNT_W'(best_idx_nxt) + CNT_W'(1);
            if (next_slot < count_r) begin
              // Close the gap: move younger entries down one slot
              idx_nxt   = next_slot[ADDR_W-1:0];
              mem_raddr = next_slot[ADDR_W-1:0];
              state_nxt = S_SHIFT;
            end else begin
              count_nxt = count_m1;
            end
          end
        end
      end

      // Write slot idx back one position lower, read the next
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r - ADDR_W'(1);
        mem_wdata = mem_rdata;
        if (last) begin
          count_nxt = count_m1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          mem_raddr = idx_r + ADDR_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      found_r <= 1'b0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
      res_r   <= res_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_pri_r <= best_pri_nxt;
    best_val_r <= best_val_nxt;
  end

  assign result = res_r;

endmodule

@@ rtl/bounded_priority_queue_core.sv @@
// Bounded priority queue of bpq_pkg::DEPTH entries (value and 8-bit priority)
// kept in arrival order in one single-port-read, single-port-write RAM. A word
// is taken when start is high and busy is low; its result appears on the out_
// ports for exactly one cycle, flagged by out_valid, and must be captured then
// since the receiver cannot stall the block. A push (or a pop on an empty
// queue) keeps busy low and its result follows in the next cycle. A pop of
// a queue holding N entries reads one entry per cycle to find the highest
// priority at or above min_priority (oldest wins on ties), holding busy high
// during the scan, and its result follows in the cycle after the scan; when
// the removed entry sits at slot k, the younger entries are moved down one
// slot per cycle through the RAM, keeping busy high until the move is done.
// The result of a pop appears before the move-down finishes.
// min_priority is written through the APB port at address 0; the user must
// write it only while the block is idle, which the block does not enforce.
module bounded_priority_queue_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Command channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_opcode,
  input  logic signed [bpq_pkg::VALUE_W-1:0] in_value,
  input  logic [bpq_pkg::PRI_W-1:0]          in_priority,
  // Result channel
  output logic                               out_valid,
  output logic signed [bpq_pkg::VALUE_W-1:0] out_value,
  output logic [bpq_pkg::PRI_W-1:0]          out_priority,
  output logic [bpq_pkg::STATUS_W-1:0]       out_status,
  output logic [bpq_pkg::FILL_W-1:0]         out_fill_count,
  // Register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bpq_pkg::APB_AW-1:0]         paddr,
  input  logic [bpq_pkg::APB_DW-1:0]         pwdata,
  output logic [bpq_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import bpq_pkg::*;

  logic [PRI_W-1:0]   min_priority;
  result_t            result;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  bpq_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .min_priority (min_priority)
  );

  bpq_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bpq_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .opcode       (in_opcode),
    .value        (in_value),
    .priority_in  (in_priority),
    .min_priority (min_priority),
    .busy         (busy),
    .result       (result),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // Drive the result word onto the ports
  assign out_valid      = result.valid;
  assign out_value      = result.value;
  assign out_priority   = result.priority_v;
  assign out_status     = result.status;
  assign out_fill_count = result.fill_count;

endmodule
